### design/hnsr_pkg.sv
`timescale 1ns / 1ps

package hnsr_pkg;

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAP_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_ROUGHEN_MODE  = 3'd2;
  localparam logic [2:0] CFG_BIG_WINDOW    = 3'd3;
  localparam logic [2:0] CFG_BLEND_FACTOR  = 3'd4;
  localparam logic [2:0] CFG_USE_SELECTION = 3'd5;

  localparam int CFG_DATA_W = 17;

  // One in Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Steps of the serial multiplier, one per bit of a Q1.16 factor.
  localparam int MUL_STEPS = 17;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         pixel_x;
    logic [5:0]         pixel_y;
    logic signed [31:0] height_in;
    logic [16:0]        weight_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] height_out;
    logic               result_kind;
  } rsp_t;

  typedef struct packed {
    logic wr_in;
    logic rd_in;
    logic pass_start;
    logic out_rd;
    logic out_done;
    logic win_init;
    logic win_acc;
    logic div_init;
    logic div_step;
    logic mul_init1;
    logic mul_init2;
    logic mul_step;
    logic apply1;
    logic apply2;
    logic write_h;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic pass_ok;
    logic win_last;
    logic div_last;
    logic mul_last;
    logic pix_last;
    logic use_sel;
  } stat_t;

endpackage

### design/heightmap_neighbour_smooth_roughen_core.sv
`timescale 1ns / 1ps

// Height map smoother and roughener. The block keeps a MAX_SIDE x MAX_SIDE map of
// signed Q16.16 heights with a Q1.16 selection weight per pixel, in two
// single-port-write, registered-read memories. A write request stores one pixel,
// and a read request returns one height through the result register. A run
// request walks the interior pixels in raster order and updates them in place:
// each pixel averages the neighbours in its clipped 3x3 or 5x5 window, moves
// toward (smooth) or away from (roughen) that average by blend_factor, and
// optionally blends by its own weight; a single result with result_kind 1
// reports the end of the pass. A run request with blend_factor above one or
// a map side below three skips the walk and only reports. The pass is paced
// by the single memory read port, the bit-serial divider that forms the
// average (HEIGHT_BITS + 5 steps) and the 17-step serial multiplier used for
// each blend term. Stores need no clearing after reset only if every pixel is
// written before it is read; the user must ensure this, as the block does not
// enforce it. Configuration is written through a plain write port and must only
// change while the block is idle.
module heightmap_neighbour_smooth_roughen_core #(
  parameter int MAX_SIDE    = 64,
  parameter int HEIGHT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  hnsr_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hnsr_pkg::rsp_t                      out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [hnsr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [6:0]  map_width_q, map_height_q;
  logic        roughen_q, big_window_q, use_sel_q;
  logic [16:0] blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 7'd64;
      map_height_q <= 7'd64;
      roughen_q    <= 1'b0;
      big_window_q <= 1'b0;
      blend_q      <= '0;
      use_sel_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hnsr_pkg::CFG_MAP_WIDTH:     map_width_q  <= cfg_data_i[6:0];
        hnsr_pkg::CFG_MAP_HEIGHT:    map_height_q <= cfg_data_i[6:0];
        hnsr_pkg::CFG_ROUGHEN_MODE:  roughen_q    <= cfg_data_i[0];
        hnsr_pkg::CFG_BIG_WINDOW:    big_window_q <= cfg_data_i[0];
        hnsr_pkg::CFG_BLEND_FACTOR:  blend_q      <= cfg_data_i[16:0];
        hnsr_pkg::CFG_USE_SELECTION: use_sel_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences each request; the datapath holds the stores,
  // the window walk, the divider, the multiplier and the result register.
  hnsr_pkg::cmd_t  cmd;
  hnsr_pkg::stat_t stat;

  hnsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_req_i.req_type),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hnsr_datapath #(
    .MAX_SIDE    (MAX_SIDE),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_i        (in_req_i),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .roughen_i    (roughen_q),
    .big_window_i (big_window_q),
    .blend_i      (blend_q),
    .use_sel_i    (use_sel_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rsp_o        (out_rsp_o)
  );

endmodule

### design/hnsr_ram.sv
`timescale 1ns / 1ps

module hnsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/hnsr_ctrl.sv
`timescale 1ns / 1ps

module hnsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       req_type_i,
  output logic             in_ready_o,
  input  hnsr_pkg::stat_t  stat_i,
  output hnsr_pkg::cmd_t   cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_RDATA = 15'h0002,
    S_FIN   = 15'h0004,
    S_WINIT = 15'h0008,
    S_ISSUE = 15'h0010,
    S_ACC   = 15'h0020,
    S_DINIT = 15'h0040,
    S_DIV   = 15'h0080,
    S_M1    = 15'h0100,
    S_MUL1  = 15'h0200,
    S_AP1   = 15'h0400,
    S_M2    = 15'h0800,
    S_MUL2  = 15'h1000,
    S_AP2   = 15'h2000,
    S_WRITE = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            hnsr_pkg::REQ_WRITE: begin
              cmd_o.wr_in = 1'b1;
            end
            hnsr_pkg::REQ_RUN: begin
              if (stat_i.pass_ok) begin
                cmd_o.pass_start = 1'b1;
                state_d = S_WINIT;
              end else begin
                state_d = S_FIN;
              end
            end
            hnsr_pkg::REQ_READ: begin
              cmd_o.rd_in = 1'b1;
              state_d = S_RDATA;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RDATA: begin
        cmd_o.out_rd = 1'b1;
        state_d = S_IDLE;
      end
      S_FIN: begin
        cmd_o.out_done = 1'b1;
        state_d = S_IDLE;
      end
      S_WINIT: begin
        cmd_o.win_init = 1'b1;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.win_acc = 1'b1;
        state_d = stat_i.win_last ? S_DINIT : S_ISSUE;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd_o.mul_init1 = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = S_AP1;
        end
      end
      S_AP1: begin
        cmd_o.apply1 = 1'b1;
        state_d = stat_i.use_sel ? S_M2 : S_WRITE;
      end
      S_M2: begin
        cmd_o.mul_init2 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = S_AP2;
        end
      end
      S_AP2: begin
        cmd_o.apply2 = 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write_h = 1'b1;
        state_d = stat_i.pix_last ? S_FIN : S_WINIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A read request always moves to the data state in the following cycle.
  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == hnsr_pkg::REQ_READ) |=> state_q == S_RDATA)
    else $error("read request did not move to the data state");

  // A run request either starts the walk or moves to the report state.
  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == hnsr_pkg::REQ_RUN) |=> (state_q == S_WINIT || state_q == S_FIN))
    else $error("run request went to an unexpected state");

endmodule

### design/hnsr_datapath.sv
`timescale 1ns / 1ps

module hnsr_datapath #(
  parameter int MAX_SIDE    = 64,
  parameter int HEIGHT_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hnsr_pkg::cmd_t  cmd_i,
  output hnsr_pkg::stat_t stat_o,
  input  hnsr_pkg::req_t  req_i,
  input  logic [6:0]      map_width_i,
  input  logic [6:0]      map_height_i,
  input  logic            roughen_i,
  input  logic            big_window_i,
  input  logic [16:0]     blend_i,
  input  logic            use_sel_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hnsr_pkg::rsp_t  rsp_o
);

  localparam int HB    = HEIGHT_BITS;
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SDW   = $clog2(MAX_SIDE + 1);
  localparam int KW    = SDW + 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADW   = $clog2(DEPTH);
  localparam int SW    = HB + 5;
  localparam int STW   = $clog2(SW);
  localparam int MW    = HB + 1;
  localparam int PW    = MW + 17;
  localparam int VW    = ((HB > 32) ? HB : 32) + 4;

  localparam logic signed [VW-1:0] HMAX_V =
    $signed({{(VW-HB+1){1'b0}}, {(HB-1){1'b1}}});
  localparam logic signed [VW-1:0] HMIN_V =
    $signed({{(VW-HB+1){1'b1}}, {(HB-1){1'b0}}});
  localparam logic signed [VW-1:0] OMAX_V = $signed({{(VW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [VW-1:0] OMIN_V = $signed({{(VW-31){1'b1}}, {31{1'b0}}});

  function automatic logic signed [HB-1:0] sat_h(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v > HMAX_V) ? HMAX_V : ((v < HMIN_V) ? HMIN_V : v);
    return r[HB-1:0];
  endfunction

  function automatic logic signed [31:0] sat_o(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v > OMAX_V) ? OMAX_V : ((v < OMIN_V) ? OMIN_V : v);
    return r[31:0];
  endfunction

  // Map geometry.
  logic [SDW-1:0] ws, hs;
  logic [KW-1:0]  rad, xk, yk, x0, y0, x1, y1, wl, hl;
  logic [CW-1:0]  x_q, y_q, xx_q, yy_q;
  logic           centre;

  assign ws = ({25'd0, map_width_i} > 32'(MAX_SIDE)) ? SDW'(MAX_SIDE) : SDW'(map_width_i);
  assign hs = ({25'd0, map_height_i} > 32'(MAX_SIDE)) ? SDW'(MAX_SIDE) : SDW'(map_height_i);
  assign wl = KW'(ws) - KW'(1);
  assign hl = KW'(hs) - KW'(1);
  assign rad = big_window_i ? KW'(2) : KW'(1);
  assign xk = KW'(x_q);
  assign yk = KW'(y_q);
  assign x0 = (xk >= rad) ? xk - rad : '0;
  assign y0 = (yk >= rad) ? yk - rad : '0;
  assign x1 = (xk + rad > wl) ? wl : xk + rad;
  assign y1 = (yk + rad > hl) ? hl : yk + rad;
  assign centre = (xx_q == x_q) && (yy_q == y_q);

  // Addresses.
  logic [ADW-1:0] in_addr, win_addr, pix_addr, raddr;
  logic           in_inside, rd_inside_q;

  assign in_inside = ({26'd0, req_i.pixel_x} < 32'(MAX_SIDE)) &&
                     ({26'd0, req_i.pixel_y} < 32'(MAX_SIDE));
  assign in_addr  = ADW'(req_i.pixel_y) * ADW'(MAX_SIDE) + ADW'(req_i.pixel_x);
  assign win_addr = ADW'(yy_q) * ADW'(MAX_SIDE) + ADW'(xx_q);
  assign pix_addr = ADW'(y_q) * ADW'(MAX_SIDE) + ADW'(x_q);
  assign raddr    = cmd_i.rd_in ? in_addr : win_addr;

  // Stores.
  logic                 h_we, w_we;
  logic [ADW-1:0]       h_waddr;
  logic [HB-1:0]        h_wdata, h_rdata;
  logic [16:0]          w_wdata, w_rdata;
  logic signed [HB-1:0] h_rd_s, val_q;

  assign h_we    = (cmd_i.wr_in && in_inside) || cmd_i.write_h;
  assign h_waddr = cmd_i.write_h ? pix_addr : in_addr;
  assign h_wdata = cmd_i.write_h ? val_q : sat_h(VW'($signed(req_i.height_in)));
  assign w_we    = cmd_i.wr_in && in_inside;
  assign w_wdata = (req_i.weight_in > hnsr_pkg::ONE_Q16) ? hnsr_pkg::ONE_Q16 : req_i.weight_in;
  assign h_rd_s  = $signed(h_rdata);

  hnsr_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (raddr),
    .rdata_o (h_rdata)
  );

  hnsr_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (in_addr),
    .wdata_i (w_wdata),
    .raddr_i (raddr),
    .rdata_o (w_rdata)
  );

  // Window sum and centre capture.
  logic signed [SW-1:0] sum_q;
  logic [4:0]           cnt_q;
  logic signed [HB-1:0] orig_q;
  logic [16:0]          wgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_start) begin
      x_q <= CW'(1);
      y_q <= CW'(1);
    end else if (cmd_i.write_h) begin
      if (xk == wl - KW'(1)) begin
        x_q <= CW'(1);
        y_q <= y_q + CW'(1);
      end else begin
        x_q <= x_q + CW'(1);
      end
    end
    if (cmd_i.win_init) begin
      xx_q  <= CW'(x0);
      yy_q  <= CW'(y0);
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.win_acc) begin
      if (centre) begin
        orig_q <= h_rd_s;
        wgt_q  <= w_rdata;
      end else begin
        sum_q <= sum_q + SW'(h_rd_s);
        cnt_q <= cnt_q + 5'd1;
      end
      if (KW'(xx_q) == x1) begin
        xx_q <= CW'(x0);
        yy_q <= yy_q + CW'(1);
      end else begin
        xx_q <= xx_q + CW'(1);
      end
    end
  end

  // Restoring divider: rounded |sum| / count, one quotient bit per cycle.
  logic [SW-1:0]  dvd_q, mag;
  logic [4:0]     rem_q;
  logic [STW-1:0] dstep_q;
  logic           sneg_q;
  logic [5:0]     dr;
  logic           dge;

  assign mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign dr  = {rem_q, dvd_q[SW-1]};
  assign dge = dr >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q   <= mag + SW'(cnt_q >> 1);
      rem_q   <= '0;
      dstep_q <= '0;
      sneg_q  <= sum_q[SW-1];
    end else if (cmd_i.div_step) begin
      rem_q   <= dge ? 5'(dr - {1'b0, cnt_q}) : dr[4:0];
      dvd_q   <= {dvd_q[SW-2:0], dge};
      dstep_q <= dstep_q + STW'(1);
    end
  end

  // Serial shift-and-add multiplier for the Q1.16 blend terms.
  logic signed [VW-1:0] orig_v, qv, avg_v, d1, d2, dsel, dabs, tv, v1, v2;
  logic [PW-1:0]        mcand_q, acc_q;
  logic [16:0]          mplier_q;
  logic [4:0]           mstep_q;
  logic                 mneg_q;
  logic [PW:0]          rnd;

  assign orig_v = VW'(orig_q);
  assign qv     = VW'($signed({1'b0, dvd_q[MW-1:0]}));
  assign avg_v  = sneg_q ? -qv : qv;
  assign d1     = avg_v - orig_v;
  assign d2     = VW'(val_q) - orig_v;
  assign dsel   = cmd_i.mul_init2 ? d2 : d1;
  assign dabs   = dsel[VW-1] ? -dsel : dsel;
  assign rnd    = {1'b0, acc_q} + (PW+1)'(32768);
  assign tv     = mneg_q ? -VW'($signed({1'b0, rnd[PW:16]}))
                         : VW'($signed({1'b0, rnd[PW:16]}));
  assign v1     = roughen_i ? orig_v - tv : orig_v + tv;
  assign v2     = orig_v + tv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init1 || cmd_i.mul_init2) begin
      mneg_q   <= dsel[VW-1];
      mcand_q  <= PW'(dabs);
      mplier_q <= cmd_i.mul_init2 ? wgt_q : blend_i;
      acc_q    <= '0;
      mstep_q  <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      mstep_q  <= mstep_q + 5'd1;
    end
    if (cmd_i.apply1) begin
      val_q <= sat_h(v1);
    end else if (cmd_i.apply2) begin
      val_q <= sat_h(v2);
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_in) begin
      rd_inside_q <= in_inside;
    end
    if (cmd_i.out_rd) begin
      rsp_o.height_out  <= rd_inside_q ? sat_o(VW'(h_rd_s)) : '0;
      rsp_o.result_kind <= hnsr_pkg::KIND_READ;
    end else if (cmd_i.out_done) begin
      rsp_o.height_out  <= '0;
      rsp_o.result_kind <= hnsr_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_rd || cmd_i.out_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.pass_ok  = (blend_i <= hnsr_pkg::ONE_Q16) && (ws >= SDW'(3)) && (hs >= SDW'(3));
  assign stat_o.win_last = (KW'(xx_q) == x1) && (KW'(yy_q) == y1);
  assign stat_o.div_last = dstep_q == STW'(SW - 1);
  assign stat_o.mul_last = mstep_q == 5'(hnsr_pkg::MUL_STEPS - 1);
  assign stat_o.pix_last = (xk == wl - KW'(1)) && (yk == hl - KW'(1));
  assign stat_o.use_sel  = use_sel_i;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_rd || cmd_i.out_done) |-> !out_valid_q)
    else $error("result register overwritten");

  // A window never holds more than twenty-four neighbours.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> (cnt_q != 5'd0 && cnt_q <= 5'd24))
    else $error("neighbour count out of range");

endmodule
